### rtl/rcm_pkg.sv
// Package for the rotation coordinate mapper: default sizes, register
// indexes, reset values and APB port widths. No dependencies.
package rcm_pkg;

  localparam int DIM_BITS_DEF       = 12;
  localparam int TRIG_FRAC_BITS_DEF = 14;
  localparam int MAG_FRAC_BITS_DEF  = 12;

  // fraction fields handed to the bilinear stage
  localparam int FRAC_OUT_BITS = 12;

  localparam int APB_DW = 32;
  localparam int APB_AW = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_COS     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SIN     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_INV_MAG = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_IN_W    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_IN_H    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_OUT_W   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_OUT_H   = 3'd6;

  localparam int IN_WIDTH_RST   = 640;
  localparam int IN_HEIGHT_RST  = 480;
  localparam int OUT_WIDTH_RST  = 640;
  localparam int OUT_HEIGHT_RST = 480;

endpackage

### rtl/rcm_if.sv
// Valid/ready channel interfaces of the rotation coordinate mapper.
// Depends on rcm_pkg for default sizes.
interface rcm_pos_if #(
  parameter int DIM_BITS = rcm_pkg::DIM_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic [DIM_BITS-1:0] out_col;
  logic [DIM_BITS-1:0] out_row;

  modport source (output valid, output out_col, output out_row, input ready);
  modport sink   (input valid, input out_col, input out_row, output ready);
endinterface

interface rcm_res_if #(
  parameter int DIM_BITS = rcm_pkg::DIM_BITS_DEF
) ();
  logic                               valid;
  logic                               ready;
  logic                               inside_res;
  logic [DIM_BITS-1:0]                source_x;
  logic [DIM_BITS-1:0]                source_y;
  logic [2*DIM_BITS-1:0]              source_offset;
  logic [rcm_pkg::FRAC_OUT_BITS-1:0]  frac_x;
  logic [rcm_pkg::FRAC_OUT_BITS-1:0]  frac_y;
  logic                               right_edge;
  logic                               bottom_edge;

  modport source (output valid, output inside_res, output source_x, output source_y,
                  output source_offset, output frac_x, output frac_y,
                  output right_edge, output bottom_edge, input ready);
  modport sink   (input valid, input inside_res, input source_x, input source_y,
                  input source_offset, input frac_x, input frac_y,
                  input right_edge, input bottom_edge, output ready);
endinterface

### rtl/rcm_cfg.sv
// APB register file of the rotation coordinate mapper.
// Depends on rcm_pkg for register indexes and reset values.
module rcm_cfg #(
  parameter int DIM_BITS       = rcm_pkg::DIM_BITS_DEF,
  parameter int TRIG_FRAC_BITS = rcm_pkg::TRIG_FRAC_BITS_DEF,
  parameter int MAG_FRAC_BITS  = rcm_pkg::MAG_FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcm_pkg::APB_AW-1:0]  paddr,
  input  logic [rcm_pkg::APB_DW-1:0]  pwdata,
  output logic [rcm_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output logic [TRIG_FRAC_BITS+1:0]   cos_o,
  output logic [TRIG_FRAC_BITS+1:0]   sin_o,
  output logic [MAG_FRAC_BITS+3:0]    inv_mag_o,
  output logic [DIM_BITS-1:0]         in_width_o,
  output logic [DIM_BITS-1:0]         in_height_o,
  output logic [DIM_BITS-1:0]         out_width_o,
  output logic [DIM_BITS-1:0]         out_height_o
);

  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam int MW = MAG_FRAC_BITS + 4;

  logic [TW-1:0]                     cos_q, sin_q;
  logic [MW-1:0]                     mag_q;
  logic [DIM_BITS-1:0]               in_w_q, in_h_q, out_w_q, out_h_q;
  logic [rcm_pkg::REG_IDX_W-1:0]     idx;
  logic                              wr_en;

  assign idx   = paddr[rcm_pkg::APB_AW-1:2];
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q   <= TW'(1) << TRIG_FRAC_BITS;
      sin_q   <= '0;
      mag_q   <= MW'(1) << MAG_FRAC_BITS;
      in_w_q  <= DIM_BITS'(rcm_pkg::IN_WIDTH_RST);
      in_h_q  <= DIM_BITS'(rcm_pkg::IN_HEIGHT_RST);
      out_w_q <= DIM_BITS'(rcm_pkg::OUT_WIDTH_RST);
      out_h_q <= DIM_BITS'(rcm_pkg::OUT_HEIGHT_RST);
    end else if (wr_en) begin
      unique case (idx)
        rcm_pkg::REG_COS:     cos_q   <= pwdata[TW-1:0];
        rcm_pkg::REG_SIN:     sin_q   <= pwdata[TW-1:0];
        rcm_pkg::REG_INV_MAG: mag_q   <= pwdata[MW-1:0];
        rcm_pkg::REG_IN_W:    in_w_q  <= pwdata[DIM_BITS-1:0];
        rcm_pkg::REG_IN_H:    in_h_q  <= pwdata[DIM_BITS-1:0];
        rcm_pkg::REG_OUT_W:   out_w_q <= pwdata[DIM_BITS-1:0];
        rcm_pkg::REG_OUT_H:   out_h_q <= pwdata[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rcm_pkg::REG_COS:     prdata = rcm_pkg::APB_DW'(cos_q);
      rcm_pkg::REG_SIN:     prdata = rcm_pkg::APB_DW'(sin_q);
      rcm_pkg::REG_INV_MAG: prdata = rcm_pkg::APB_DW'(mag_q);
      rcm_pkg::REG_IN_W:    prdata = rcm_pkg::APB_DW'(in_w_q);
      rcm_pkg::REG_IN_H:    prdata = rcm_pkg::APB_DW'(in_h_q);
      rcm_pkg::REG_OUT_W:   prdata = rcm_pkg::APB_DW'(out_w_q);
      rcm_pkg::REG_OUT_H:   prdata = rcm_pkg::APB_DW'(out_h_q);
      default:              prdata = '0;
    endcase
  end

  assign cos_o        = cos_q;
  assign sin_o        = sin_q;
  assign inv_mag_o    = mag_q;
  assign in_width_o   = in_w_q;
  assign in_height_o  = in_h_q;
  assign out_width_o  = out_w_q;
  assign out_height_o = out_h_q;

endmodule

### rtl/rcm_rotate.sv
// Rotation half of the mapper pipeline: centering, four products, sums.
// Three register stages with elastic valid/ready. Depends on rcm_pkg.
module rcm_rotate #(
  parameter int DIM_BITS       = rcm_pkg::DIM_BITS_DEF,
  parameter int TRIG_FRAC_BITS = rcm_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic [DIM_BITS-1:0]                   col_i,
  input  logic [DIM_BITS-1:0]                   row_i,
  input  logic [TRIG_FRAC_BITS+1:0]             cos_i,
  input  logic [TRIG_FRAC_BITS+1:0]             sin_i,
  input  logic [DIM_BITS-1:0]                   out_width_i,
  input  logic [DIM_BITS-1:0]                   out_height_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic signed [DIM_BITS+TRIG_FRAC_BITS+4:0] rx_o,
  output logic signed [DIM_BITS+TRIG_FRAC_BITS+4:0] ry_o
);

  localparam int UW  = DIM_BITS + 2;
  localparam int TW  = TRIG_FRAC_BITS + 2;
  localparam int PW1 = UW + TW;
  localparam int RW  = PW1 + 1;

  logic [2:0] v_q;
  logic [2:0] en;

  logic signed [UW-1:0]  u_q, v_pos_q;
  logic signed [TW-1:0]  cos_s, sin_s;
  logic signed [PW1-1:0] ucos_d, vsin_d, vcos_d, usin_d;
  logic signed [PW1-1:0] ucos_q, vsin_q, vcos_q, usin_q;
  logic signed [RW-1:0]  rx_q, ry_q;

  assign en[2] = !v_q[2] || ready_i;
  assign en[1] = !v_q[1] || en[2];
  assign en[0] = !v_q[0] || en[1];
  assign ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  assign cos_s  = cos_i;
  assign sin_s  = sin_i;
  assign ucos_d = u_q * cos_s;
  assign vsin_d = v_pos_q * sin_s;
  assign vcos_d = v_pos_q * cos_s;
  assign usin_d = u_q * sin_s;

  // u, v in half pixels relative to the output frame center
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      u_q     <= {1'b0, col_i, 1'b0} - {2'b00, out_width_i};
      v_pos_q <= {1'b0, row_i, 1'b0} - {2'b00, out_height_i};
    end
    if (en[1]) begin
      ucos_q <= ucos_d;
      vsin_q <= vsin_d;
      vcos_q <= vcos_d;
      usin_q <= usin_d;
    end
    if (en[2]) begin
      rx_q <= RW'(ucos_q) - RW'(vsin_q);
      ry_q <= RW'(vcos_q) + RW'(usin_q);
    end
  end

  assign valid_o = v_q[2];
  assign rx_o    = rx_q;
  assign ry_o    = ry_q;

endmodule

### rtl/rcm_locate.sv
// Scaling and source lookup half of the pipeline: magnification products,
// recentering with frame test, address and edge flags into the output word.
// Depends on rcm_pkg and rcm_res_if.
module rcm_locate #(
  parameter int DIM_BITS       = rcm_pkg::DIM_BITS_DEF,
  parameter int TRIG_FRAC_BITS = rcm_pkg::TRIG_FRAC_BITS_DEF,
  parameter int MAG_FRAC_BITS  = rcm_pkg::MAG_FRAC_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  output logic                                      ready_o,
  input  logic signed [DIM_BITS+TRIG_FRAC_BITS+4:0] rx_i,
  input  logic signed [DIM_BITS+TRIG_FRAC_BITS+4:0] ry_i,
  input  logic [MAG_FRAC_BITS+3:0]                  inv_mag_i,
  input  logic [DIM_BITS-1:0]                       in_width_i,
  input  logic [DIM_BITS-1:0]                       in_height_i,
  rcm_res_if.source                                 res_o
);

  localparam int RW  = DIM_BITS + TRIG_FRAC_BITS + 5;
  localparam int MW  = MAG_FRAC_BITS + 4;
  localparam int P2W = RW + MW + 1;
  localparam int PXW = P2W + 1;
  localparam int S   = TRIG_FRAC_BITS + MAG_FRAC_BITS + 1;
  localparam int FW  = rcm_pkg::FRAC_OUT_BITS;
  localparam int OW  = 2 * DIM_BITS;

  logic [2:0] v_q;
  logic [2:0] en;

  logic signed [MW:0]      mag_s;
  logic signed [P2W-1:0]   prx_d, pry_d, prx_q, pry_q;
  logic signed [PXW-1:0]   px, py, cx, cy, limx, limy;
  logic                    in_x, in_y;

  logic                    ins_q;
  logic [DIM_BITS-1:0]     sx_q, sy_q;
  logic [FW-1:0]           fx_q, fy_q;

  logic                    o_ins_q, o_re_q, o_be_q;
  logic [DIM_BITS-1:0]     o_sx_q, o_sy_q;
  logic [OW-1:0]           o_off_q, off_d;
  logic [FW-1:0]           o_fx_q, o_fy_q;
  logic [DIM_BITS-1:0]     w_last, h_last;

  assign en[2] = !v_q[2] || res_o.ready;
  assign en[1] = !v_q[1] || en[2];
  assign en[0] = !v_q[0] || en[1];
  assign ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  assign mag_s = {1'b0, inv_mag_i};
  assign prx_d = rx_i * mag_s;
  assign pry_d = ry_i * mag_s;

  // recenter on the input frame: add half the frame size
  assign cx   = PXW'(in_width_i) << (S - 1);
  assign cy   = PXW'(in_height_i) << (S - 1);
  assign limx = PXW'(in_width_i) << S;
  assign limy = PXW'(in_height_i) << S;
  assign px   = {prx_q[P2W-1], prx_q} + cx;
  assign py   = {pry_q[P2W-1], pry_q} + cy;
  assign in_x = !px[PXW-1] && (px < limx);
  assign in_y = !py[PXW-1] && (py < limy);

  assign off_d  = OW'(sy_q) * OW'(in_width_i) + OW'(sx_q);
  assign w_last = in_width_i - DIM_BITS'(1);
  assign h_last = in_height_i - DIM_BITS'(1);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      prx_q <= prx_d;
      pry_q <= pry_d;
    end
    if (en[1]) begin
      ins_q <= in_x && in_y;
      sx_q  <= px[S +: DIM_BITS];
      sy_q  <= py[S +: DIM_BITS];
      fx_q  <= px[S-FW +: FW];
      fy_q  <= py[S-FW +: FW];
    end
    if (en[2]) begin
      o_ins_q <= ins_q;
      if (ins_q) begin
        o_sx_q  <= sx_q;
        o_sy_q  <= sy_q;
        o_off_q <= off_d;
        o_fx_q  <= fx_q;
        o_fy_q  <= fy_q;
        o_re_q  <= (sx_q == w_last);
        o_be_q  <= (sy_q == h_last);
      end else begin
        o_sx_q  <= '0;
        o_sy_q  <= '0;
        o_off_q <= '0;
        o_fx_q  <= '0;
        o_fy_q  <= '0;
        o_re_q  <= 1'b0;
        o_be_q  <= 1'b0;
      end
    end
  end

  assign res_o.valid         = v_q[2];
  assign res_o.inside_res    = o_ins_q;
  assign res_o.source_x      = o_sx_q;
  assign res_o.source_y      = o_sy_q;
  assign res_o.source_offset = o_off_q;
  assign res_o.frac_x        = o_fx_q;
  assign res_o.frac_y        = o_fy_q;
  assign res_o.right_edge    = o_re_q;
  assign res_o.bottom_edge   = o_be_q;

endmodule

### rtl/rotation_coordinate_mapper.sv
// Top level of the rotation coordinate mapper: APB registers, rotation
// pipeline and source lookup pipeline. Depends on rcm_pkg, rcm_if, rcm_cfg,
// rcm_rotate and rcm_locate.
//
//   channel   direction  protocol     word
//   pos_i     in         valid/ready  out_col, out_row
//   res_o     out        valid/ready  inside_res .. bottom_edge
//   APB       in/out     psel/penable seven config registers at 4*index
//
// Six register stages, one word per clock while the output is not stalled;
// the multipliers of stages two and four set the depth.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// A full stage holds only while its successor is full and held, so bubbles
// close up and a stalled output freezes its word without loss.
module rotation_coordinate_mapper #(
  parameter int DIM_BITS       = rcm_pkg::DIM_BITS_DEF,
  parameter int TRIG_FRAC_BITS = rcm_pkg::TRIG_FRAC_BITS_DEF,
  parameter int MAG_FRAC_BITS  = rcm_pkg::MAG_FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcm_pkg::APB_AW-1:0]  paddr,
  input  logic [rcm_pkg::APB_DW-1:0]  pwdata,
  output logic [rcm_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  rcm_pos_if.sink                     pos_i,
  rcm_res_if.source                   res_o
);

  localparam int RW = DIM_BITS + TRIG_FRAC_BITS + 5;

  logic [TRIG_FRAC_BITS+1:0] cos_w, sin_w;
  logic [MAG_FRAC_BITS+3:0]  mag_w;
  logic [DIM_BITS-1:0]       in_w, in_h, out_w, out_h;
  logic                      rot_valid, rot_ready;
  logic signed [RW-1:0]      rx_w, ry_w;

  rcm_cfg #(
    .DIM_BITS      (DIM_BITS),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS),
    .MAG_FRAC_BITS (MAG_FRAC_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cos_o       (cos_w),
    .sin_o       (sin_w),
    .inv_mag_o   (mag_w),
    .in_width_o  (in_w),
    .in_height_o (in_h),
    .out_width_o (out_w),
    .out_height_o(out_h)
  );

  rcm_rotate #(
    .DIM_BITS      (DIM_BITS),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_rotate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (pos_i.valid),
    .ready_o     (pos_i.ready),
    .col_i       (pos_i.out_col),
    .row_i       (pos_i.out_row),
    .cos_i       (cos_w),
    .sin_i       (sin_w),
    .out_width_i (out_w),
    .out_height_i(out_h),
    .valid_o     (rot_valid),
    .ready_i     (rot_ready),
    .rx_o        (rx_w),
    .ry_o        (ry_w)
  );

  rcm_locate #(
    .DIM_BITS      (DIM_BITS),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS),
    .MAG_FRAC_BITS (MAG_FRAC_BITS)
  ) u_locate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (rot_valid),
    .ready_o    (rot_ready),
    .rx_i       (rx_w),
    .ry_i       (ry_w),
    .inv_mag_i  (mag_w),
    .in_width_i (in_w),
    .in_height_i(in_h),
    .res_o      (res_o)
  );

endmodule

### rtl/rcm_checker.sv
// Port-level checks for rotation_coordinate_mapper, attached by bind.
// Depends on rcm_pkg for field widths.
module rcm_checker #(
  parameter int DIM_BITS = rcm_pkg::DIM_BITS_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              inside_res,
  input logic [DIM_BITS-1:0]               source_x,
  input logic [DIM_BITS-1:0]               source_y,
  input logic [2*DIM_BITS-1:0]             source_offset,
  input logic [rcm_pkg::FRAC_OUT_BITS-1:0] frac_x,
  input logic [rcm_pkg::FRAC_OUT_BITS-1:0] frac_y,
  input logic                              right_edge,
  input logic                              bottom_edge
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(inside_res) && $stable(source_x)
      && $stable(source_y) && $stable(source_offset) && $stable(frac_x)
      && $stable(frac_y) && $stable(right_edge) && $stable(bottom_edge))
    else $error("stalled output word changed");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !inside_res |-> source_x == '0 && source_y == '0
      && source_offset == '0 && frac_x == '0 && frac_y == '0
      && !right_edge && !bottom_edge)
    else $error("outside point with nonzero fields");

  a_edge_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (right_edge || bottom_edge) |-> inside_res)
    else $error("edge flag on outside point");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output not blocked");

endmodule

bind rotation_coordinate_mapper rcm_checker #(
  .DIM_BITS(DIM_BITS)
) u_rcm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (pos_i.valid),
  .in_ready     (pos_i.ready),
  .out_valid    (res_o.valid),
  .out_ready    (res_o.ready),
  .inside_res   (res_o.inside_res),
  .source_x     (res_o.source_x),
  .source_y     (res_o.source_y),
  .source_offset(res_o.source_offset),
  .frac_x       (res_o.frac_x),
  .frac_y       (res_o.frac_y),
  .right_edge   (res_o.right_edge),
  .bottom_edge  (res_o.bottom_edge)
);
